// ===== rtl/pnm_image_stream_parser_defines.svh =====
// Assertion macros shared by the PNM stream parser RTL.
`ifndef PNM_IMAGE_STREAM_PARSER_DEFINES_SVH
`define PNM_IMAGE_STREAM_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pis_pkg.sv =====
// Types, codes and constants of the PNM image stream parser.
package pis_pkg;

   // Largest width or height that is accepted.
   localparam int unsigned MAX_DIM = 16384;
   // Result queue depth; a power of two so the pointers wrap on their own.
   localparam int unsigned RSP_QUEUE_DEPTH = 4;

   // Parser phases.
   typedef enum logic [3:0] {
      PH_MAGIC0,
      PH_MAGIC1,
      PH_WIDTH,
      PH_HEIGHT,
      PH_MAXVAL,
      PH_ASCII,
      PH_BIN,
      PH_DRAIN
   } pis_phase_type;

   // Result kinds.
   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_SAMPLE = 3'd1;
   localparam logic [2:0] KIND_RAW    = 3'd2;
   localparam logic [2:0] KIND_DONE   = 3'd3;
   localparam logic [2:0] KIND_ERROR  = 3'd4;

   // Image types.
   localparam logic [2:0] TYPE_P1 = 3'd0;
   localparam logic [2:0] TYPE_P2 = 3'd1;
   localparam logic [2:0] TYPE_P3 = 3'd2;
   localparam logic [2:0] TYPE_P5 = 3'd3;
   localparam logic [2:0] TYPE_P6 = 3'd4;

   // Error codes.
   localparam logic [1:0] ERR_MAGIC = 2'd0;
   localparam logic [1:0] ERR_TYPE  = 2'd1;
   localparam logic [1:0] ERR_FIELD = 2'd2;
   localparam logic [1:0] ERR_SIZE  = 2'd3;

   // Characters the parser looks for.
   localparam logic [7:0] CHR_P     = 8'h50;
   localparam logic [7:0] CHR_HASH  = 8'h23;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_0     = 8'h30;
   localparam logic [7:0] CHR_1     = 8'h31;
   localparam logic [7:0] CHR_2     = 8'h32;
   localparam logic [7:0] CHR_3     = 8'h33;
   localparam logic [7:0] CHR_5     = 8'h35;
   localparam logic [7:0] CHR_6     = 8'h36;
   localparam logic [7:0] CHR_9     = 8'h39;

   // Sample constants.
   localparam logic [31:0] WIDE_THRESHOLD = 32'd256;
   localparam logic [31:0] DEFAULT_MAXVAL = 32'd255;
   localparam logic [15:0] PBM_WHITE      = 16'd255;

   // One input transaction: a file byte.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_file;
   } pis_req_type;

   // One result transaction.
   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  image_type;
      logic [14:0] width;
      logic [14:0] height;
      logic [31:0] maxval;
      logic        wide_samples;
      logic [15:0] sample_value;
      logic [1:0]  error_code;
      logic [30:0] count;
      logic        last_of_run;
   } pis_rsp_type;

endpackage

// ===== rtl/pnm_image_stream_parser.sv =====
// PNM image stream parser: header, sample, raw byte, done and error results from a byte stream.

// An accepted file byte is held in the input register and parsed from there; when
// the parse step fires, it writes its zero, one or two result transactions into a
// four-entry result queue, whose registers offer them in order on rsp_data.
// One byte is accepted every cycle as long as the queue has two free entries, or one
// free entry and a result leaves in that cycle; a byte that causes two results
// (header plus first data item, or last sample plus done) takes two queue entries,
// so the input rate follows the output rate over such bytes. The parse cycle holds
// the decimal accumulate, the width-times-height multiply that sizes the data
// section, and the state update.
`include "pnm_image_stream_parser_defines.svh"

module pnm_image_stream_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pis_pkg::pis_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pis_pkg::pis_rsp_type rsp_data
);
   import pis_pkg::*;

   localparam int unsigned PtrWidth   = $clog2(RSP_QUEUE_DEPTH);
   localparam int unsigned CountWidth = $clog2(RSP_QUEUE_DEPTH + 1);

   // Parser state carried from byte to byte.
   typedef struct packed {
      pis_phase_type phase;
      logic [2:0]    pkind;
      logic          cmt;
      logic          act;
      logic [31:0]   acc;
      logic [14:0]   wr;
      logic [14:0]   hr;
      logic [31:0]   mv;
      logic [30:0]   rem;
      logic [30:0]   emi;
      logic          dov;
      logic          dpend;
   } pis_state_type;

   // Results produced by one byte.
   typedef struct packed {
      pis_rsp_type [1:0] r;
      logic [1:0]        n;
   } pis_out_type;

   typedef struct packed {
      pis_state_type s;
      pis_out_type   o;
   } pis_ctx_type;

   // Result record with only kind, value, error and count filled in.
   function automatic pis_rsp_type make_rsp(logic [2:0] kind, logic [15:0] sval,
                                            logic [1:0] err, logic [30:0] cnt);
      pis_rsp_type r;
      r              = '0;
      r.kind         = kind;
      r.sample_value = sval;
      r.error_code   = err;
      r.count        = cnt;
      return r;
   endfunction

   // Append a result to the byte's result list.
   function automatic pis_out_type push_rsp(pis_out_type o, pis_rsp_type r);
      pis_out_type t;
      t = o;
      if (o.n == 2'd0) begin
         t.r[0] = r;
         t.n    = 2'd1;
      end else if (o.n == 2'd1) begin
         t.r[1] = r;
         t.n    = 2'd2;
      end
      return t;
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return (b >= CHR_0) && (b <= CHR_9);
   endfunction

   function automatic logic is_space(logic [7:0] b);
      return (b == CHR_SPACE) || (b == CHR_TAB) || (b == CHR_CR) || (b == CHR_LF);
   endfunction

   function automatic logic in_text_phase(pis_phase_type p);
      return (p == PH_WIDTH) || (p == PH_HEIGHT) || (p == PH_MAXVAL) || (p == PH_ASCII);
   endfunction

   function automatic pis_state_type reset_state();
      pis_state_type s;
      s       = '0;
      s.phase = PH_MAGIC0;
      s.mv    = DEFAULT_MAXVAL;
      return s;
   endfunction

   function automatic pis_ctx_type fail_item(pis_ctx_type c, logic [1:0] code);
      pis_ctx_type t;
      t         = c;
      t.o       = push_rsp(c.o, make_rsp(KIND_ERROR, 16'd0, code, 31'd0));
      t.s.phase = PH_DRAIN;
      return t;
   endfunction

   // Done result, or held for the next byte when two results already stand.
   function automatic pis_ctx_type finish_data(pis_ctx_type c);
      pis_ctx_type t;
      t = c;
      if (c.o.n == 2'd2) begin
         t.s.dpend = 1'b1;
      end else begin
         t.o = push_rsp(c.o, make_rsp(KIND_DONE, 16'd0, ERR_MAGIC, c.s.emi));
      end
      t.s.phase = PH_DRAIN;
      return t;
   endfunction

   function automatic pis_ctx_type finish_header(pis_ctx_type c, logic [30:0] total);
      pis_ctx_type t;
      pis_rsp_type r;
      t = c;
      r = make_rsp(KIND_HEADER, 16'd0, ERR_MAGIC, 31'd0);
      if (c.s.dov) begin
         t = fail_item(c, ERR_SIZE);
      end else begin
         r.image_type   = c.s.pkind;
         r.width        = c.s.wr;
         r.height       = c.s.hr;
         r.maxval       = c.s.mv;
         r.wide_samples = c.s.mv >= WIDE_THRESHOLD;
         t.o            = push_rsp(c.o, r);
         t.s.rem        = total;
         t.s.emi        = 31'd0;
         t.s.phase      = (c.s.pkind >= TYPE_P5) ? PH_BIN : PH_ASCII;
         if (total == 31'd0) begin
            t = finish_data(t);
         end
      end
      return t;
   endfunction

   function automatic pis_ctx_type raw_byte(pis_ctx_type c, logic [7:0] b);
      pis_ctx_type t;
      t       = c;
      t.o     = push_rsp(c.o, make_rsp(KIND_RAW, {8'd0, b}, ERR_MAGIC, 31'd0));
      t.s.emi = c.s.emi + 31'd1;
      t.s.rem = c.s.rem - 31'd1;
      if (t.s.rem == 31'd0) begin
         t = finish_data(t);
      end
      return t;
   endfunction

   // A decimal number has ended; store it where the phase says.
   function automatic pis_ctx_type complete_number(pis_ctx_type c, logic [31:0] v,
                                                   logic big, logic [30:0] total);
      pis_ctx_type t;
      logic [15:0] s;
      t     = c;
      s     = 16'd0;
      t.s.act = 1'b0;
      case (c.s.phase)
         PH_WIDTH: begin
            if (big) t.s.dov = 1'b1;
            t.s.wr    = v[14:0];
            t.s.phase = PH_HEIGHT;
         end
         PH_HEIGHT: begin
            if (big) t.s.dov = 1'b1;
            t.s.hr = v[14:0];
            if (c.s.pkind == TYPE_P1) begin
               t = finish_header(t, total);
            end else begin
               t.s.phase = PH_MAXVAL;
            end
         end
         PH_MAXVAL: begin
            t.s.mv = v;
            t      = finish_header(t, total);
         end
         PH_ASCII: begin
            if (c.s.pkind == TYPE_P1) begin
               s = (v == 32'd0) ? PBM_WHITE : 16'd0;
            end else if (c.s.mv >= WIDE_THRESHOLD) begin
               s = v[15:0];
            end else begin
               s = {8'd0, v[7:0]};
            end
            t.o     = push_rsp(c.o, make_rsp(KIND_SAMPLE, s, ERR_MAGIC, 31'd0));
            t.s.emi = c.s.emi + 31'd1;
            t.s.rem = c.s.rem - 31'd1;
            if (t.s.rem == 31'd0) begin
               t = finish_data(t);
            end
         end
         default: begin
         end
      endcase
      return t;
   endfunction

   // Byte seen between tokens.
   function automatic pis_ctx_type skip_byte(pis_ctx_type c, logic [7:0] b);
      pis_ctx_type t;
      t = c;
      if (!is_space(b)) begin
         if (b == CHR_HASH) begin
            t.s.cmt = 1'b1;
         end else if (is_digit(b)) begin
            t.s.act = 1'b1;
            t.s.acc = {28'd0, b[3:0]};
         end else if (c.s.phase == PH_ASCII) begin
            t = finish_data(c);
         end else begin
            t = fail_item(c, ERR_FIELD);
         end
      end
      return t;
   endfunction

   function automatic pis_ctx_type text_byte(pis_ctx_type c, logic [7:0] b, logic [31:0] v,
                                             logic big, logic [30:0] total,
                                             logic [31:0] acc_dig);
      pis_ctx_type   t;
      pis_phase_type prev;
      t    = c;
      prev = c.s.phase;
      if (c.s.cmt) begin
         if (b == CHR_LF) t.s.cmt = 1'b0;
      end else if (c.s.act) begin
         if (is_digit(b)) begin
            t.s.acc = acc_dig;
         end else begin
            t = complete_number(c, v, big, total);
            if ((prev != PH_ASCII) && ((t.s.phase == PH_ASCII) || (t.s.phase == PH_BIN))) begin
               // Byte that ended the header: whitespace is eaten, other bytes are raw data or, in text, token bytes.
               if (!is_space(b)) begin
                  if (t.s.phase == PH_BIN) begin
                     t = raw_byte(t, b);
                  end else begin
                     t = skip_byte(t, b);
                  end
               end
            end else if (in_text_phase(t.s.phase)) begin
               t = skip_byte(t, b);
            end
         end
      end else begin
         t = skip_byte(c, b);
      end
      return t;
   endfunction

   pis_state_type state_ff, state_in;
   pis_req_type   item_ff;
   logic          item_vld_ff, item_vld_in;
   pis_rsp_type   queue_ff [RSP_QUEUE_DEPTH];
   logic [PtrWidth-1:0]   head_ff, head_in, tail_ff, tail_in, tail_plus1;
   logic [CountWidth-1:0] count_ff, count_in;
   logic          req_accept, fire, pop;
   pis_ctx_type   step;

   // Number value at the point where it completes, and the data size it implies.
   logic [31:0] acc_dig, v_sel;
   logic        v_big, wide_c, chan3, binary;
   logic [14:0] hgt_c;
   logic [29:0] area;
   logic [31:0] area3, total32;
   logic [30:0] total;

   always_comb begin
      acc_dig = {state_ff.acc[28:0], 3'b000} + {state_ff.acc[30:0], 1'b0}
              + {28'd0, item_ff.in_byte[3:0]};
      if (state_ff.act && !state_ff.cmt && is_digit(item_ff.in_byte)) begin
         v_sel = acc_dig;
      end else if (!state_ff.act && !state_ff.cmt && is_digit(item_ff.in_byte)) begin
         v_sel = {28'd0, item_ff.in_byte[3:0]};
      end else begin
         v_sel = state_ff.acc;
      end
      v_big   = v_sel > 32'(MAX_DIM);
      hgt_c   = (state_ff.phase == PH_HEIGHT) ? v_sel[14:0] : state_ff.hr;
      area    = 30'(state_ff.wr) * 30'(hgt_c);
      chan3   = (state_ff.pkind == TYPE_P3) || (state_ff.pkind == TYPE_P6);
      binary  = (state_ff.pkind == TYPE_P5) || (state_ff.pkind == TYPE_P6);
      area3   = {2'b00, area} + (chan3 ? {1'b0, area, 1'b0} : 32'd0);
      wide_c  = (state_ff.phase == PH_MAXVAL) ? (v_sel >= WIDE_THRESHOLD)
                                              : (state_ff.mv >= WIDE_THRESHOLD);
      total32 = (binary && wide_c) ? {area3[30:0], 1'b0} : area3;
      total   = total32[30:0];
   end

   // Parse the byte in the input register.
   always_comb begin
      pis_ctx_type c;
      logic [7:0]  b;
      logic        eof;
      b   = item_ff.in_byte;
      eof = item_ff.end_of_file;
      c.s = state_ff;
      c.o = '0;
      if (c.s.dpend) begin
         c.s.dpend = 1'b0;
         c.o       = push_rsp(c.o, make_rsp(KIND_DONE, 16'd0, ERR_MAGIC, c.s.emi));
      end
      case (state_ff.phase)
         PH_MAGIC0: begin
            if (eof || (b != CHR_P)) begin
               c = fail_item(c, ERR_MAGIC);
            end else begin
               c.s       = reset_state();
               c.s.phase = PH_MAGIC1;
            end
         end
         PH_MAGIC1: begin
            if (eof) begin
               c = fail_item(c, ERR_MAGIC);
            end else begin
               c.s.phase = PH_WIDTH;
               case (b)
                  CHR_1:   c.s.pkind = TYPE_P1;
                  CHR_2:   c.s.pkind = TYPE_P2;
                  CHR_3:   c.s.pkind = TYPE_P3;
                  CHR_5:   c.s.pkind = TYPE_P5;
                  CHR_6:   c.s.pkind = TYPE_P6;
                  default: c = fail_item(c, ERR_TYPE);
               endcase
            end
         end
         PH_BIN: begin
            c = raw_byte(c, b);
         end
         PH_DRAIN: begin
         end
         default: begin
            c = text_byte(c, b, v_sel, v_big, total, acc_dig);
         end
      endcase
      // End of file closes whatever is open and rearms the magic check.
      if (eof) begin
         if (c.s.act && in_text_phase(c.s.phase)) begin
            c = complete_number(c, v_sel, v_big, total);
         end
         if ((c.s.phase == PH_WIDTH) || (c.s.phase == PH_HEIGHT) ||
             (c.s.phase == PH_MAXVAL)) begin
            c = fail_item(c, ERR_FIELD);
         end else if ((c.s.phase == PH_ASCII) || (c.s.phase == PH_BIN)) begin
            c = finish_data(c);
         end
         c.s.cmt   = 1'b0;
         c.s.act   = 1'b0;
         c.s.phase = PH_MAGIC0;
      end
      if (c.o.n == 2'd1) begin
         c.o.r[0].last_of_run = 1'b1;
      end else if (c.o.n == 2'd2) begin
         c.o.r[1].last_of_run = 1'b1;
      end
      step = c;
   end

   // Handshakes: the parse step fires when the queue can take two results.
   assign pop        = rsp_valid && !rsp_stall;
   assign fire       = item_vld_ff &&
                       ((count_ff <= CountWidth'(RSP_QUEUE_DEPTH - 2)) ||
                        (pop && (count_ff == CountWidth'(RSP_QUEUE_DEPTH - 1))));
   assign req_stall  = item_vld_ff && !fire;
   assign req_accept = req_valid && !req_stall;

   assign item_vld_in = req_accept || (item_vld_ff && !fire);
   assign state_in    = fire ? step.s : state_ff;
   assign tail_plus1  = tail_ff + PtrWidth'(1);
   assign tail_in     = fire ? (tail_ff + PtrWidth'(step.o.n)) : tail_ff;
   assign head_in     = head_ff + PtrWidth'(pop);
   assign count_in    = count_ff - CountWidth'(pop)
                      + (fire ? CountWidth'(step.o.n) : CountWidth'(0));

   assign rsp_valid = count_ff != CountWidth'(0);
   assign rsp_data  = queue_ff[head_ff];

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= reset_state();
         item_vld_ff <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         item_vld_ff <= item_vld_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

   // Input register and result queue storage.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
      if (fire && (step.o.n != 2'd0)) begin
         queue_ff[tail_ff] <= step.o.r[0];
      end
      if (fire && (step.o.n == 2'd2)) begin
         queue_ff[tail_plus1] <= step.o.r[1];
      end
   end

   // Checks on the parser's own bookkeeping.
   `PIS_ASSERT_NEXT(a_result_offered, clock, reset, fire && (step.o.n != 2'd0), rsp_valid, "result written but not offered")
   `PIS_ASSERT_IMPLIES(a_pending_done_phase, clock, reset, state_ff.dpend, (state_ff.phase == PH_DRAIN) || (state_ff.phase == PH_MAGIC0), "held done outside drain")
   `PIS_ASSERT_IMPLIES(a_number_not_comment, clock, reset, state_ff.act, !state_ff.cmt, "number and comment both open")
   `PIS_ASSERT_IMPLIES(a_full_queue_holds, clock, reset, count_ff == CountWidth'(RSP_QUEUE_DEPTH), !fire, "parse step into full queue")

endmodule
